// ===== hdl/multi_channel_timer_bank_macros.svh =====
// Assertion macros for the timer bank checker.
// Depends on nothing; included by the checker file.
`ifndef MULTI_CHANNEL_TIMER_BANK_MACROS_SVH
`define MULTI_CHANNEL_TIMER_BANK_MACROS_SVH

// a implies b in the same cycle
`define MCTB_ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("mctb: %s failed", "label");

// a implies b in the next cycle
`define MCTB_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("mctb: %s failed", "label");

`endif

// ===== hdl/mctb_pkg.sv =====
// Shared constants, op codes and the broadcast command type of the timer bank.
// No dependencies; used by mctb_cell and multi_channel_timer_bank.
package mctb_pkg;

	localparam int NUM_TIMERS  = 16;
	localparam int COUNT_WIDTH = 32;

	// fixed field widths
	localparam int OP_W     = 3;
	localparam int CHAN_W   = 4;
	localparam int TICKS_W  = 32;
	localparam int MASK_W   = 16;
	localparam int NEW_ID_W = 4;

	// allocation counter holds 1..NUM_TIMERS
	localparam int ALLOC_W = $clog2(NUM_TIMERS + 1);
	// index width wide enough for both a channel field and a cell index
	localparam int IDX_W   = (ALLOC_W > CHAN_W) ? ALLOC_W : CHAN_W;
	// fire vector padded so the mask can always take its low 16 bits
	localparam int FIRE_W  = (NUM_TIMERS > MASK_W) ? NUM_TIMERS : MASK_W;

	localparam int RESERVED_CHANNEL   = 0;
	localparam int FIRST_USER_CHANNEL = RESERVED_CHANNEL + 1;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
	localparam logic [OP_W-1:0] OP_START = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

	// command broadcast to every cell
	typedef struct packed {
		logic                   tick;
		logic                   load;
		logic                   halt;
		logic [COUNT_WIDTH-1:0] value;
		logic                   periodic;
	} cmd_t;

endpackage

// ===== hdl/mctb_cell.sv =====
// One timer channel: count, period, mode and running flag.
// Depends on mctb_pkg; instantiated in a row by multi_channel_timer_bank.
module mctb_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mctb_pkg::cmd_t                      cmd,
	input  logic                                sel,
	input  logic                                alloc,
	input  logic                                tick_en,
	input  logic                                query_in,
	output logic                                query_out,
	output logic                                fire
);

	logic [mctb_pkg::COUNT_WIDTH-1:0] count_q;
	logic [mctb_pkg::COUNT_WIDTH-1:0] period_q;
	logic [mctb_pkg::COUNT_WIDTH-1:0] dec;
	logic                             periodic_q;
	logic                             run_q;
	logic                             step;

	// decrement path for a tick
	assign dec  = count_q - mctb_pkg::COUNT_WIDTH'(1);
	assign step = cmd.tick & tick_en & run_q;
	assign fire = step & (dec == '0);

	// query answer travels down the row: the selected cell adds its zero test
	assign query_out = query_in | (sel & (count_q == '0));

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			period_q   <= '0;
			periodic_q <= 1'b0;
			run_q      <= 1'b0;
		end else if (cmd.load & sel & alloc) begin
			count_q    <= cmd.value;
			period_q   <= cmd.value;
			periodic_q <= cmd.periodic;
			run_q      <= 1'b1;
		end else if (cmd.halt & sel) begin
			run_q <= 1'b0;
		end else if (step) begin
			if (dec == '0) begin
				if (periodic_q) begin
					count_q <= period_q;
				end else begin
					count_q <= dec;
					run_q   <= 1'b0;
				end
			end else begin
				count_q <= dec;
			end
		end
	end

endmodule

// ===== hdl/multi_channel_timer_bank.sv =====
// Top level of the timer bank: op decode, allocation counter, cell row, result registers.
// Depends on mctb_pkg and mctb_cell.
//
// Usage: a transaction is offered on op/channel/ticks/mode with start high; it is
// taken at a rising edge where start is high and busy is low. busy stays low, so a
// transaction may be taken every cycle.
// Ops: tick decrements every running allocated channel except reserved channel 0;
// allocate hands out ids from 1 upward; start loads period and count and runs an
// allocated channel; stop clears running; query reports whether the channel's
// count is zero. The result appears in the cycle after acceptance, with done high
// for a single cycle. Throughput: one transaction per cycle; every channel cell
// updates in the same cycle, and the query answer ripples along the row of cells.
// Result fields not belonging to the op read zero.
// Reset: all counts, periods, modes and running flags clear, the allocation
// counter returns to one, done is low.
// The receiver cannot stall: each result is shown for exactly one cycle.
module multi_channel_timer_bank (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [mctb_pkg::OP_W-1:0]        op,
	input  logic [mctb_pkg::CHAN_W-1:0]      channel,
	input  logic [mctb_pkg::TICKS_W-1:0]     ticks,
	input  logic                             mode,
	output logic                             done,
	output logic [mctb_pkg::MASK_W-1:0]      expired_mask,
	output logic [mctb_pkg::NEW_ID_W-1:0]    new_id,
	output logic                             alloc_ok,
	output logic                             is_expired
);

	logic                             accept;
	mctb_pkg::cmd_t                   cmd;
	logic [mctb_pkg::ALLOC_W-1:0]     alloc_cnt_q;
	logic                             alloc_avail;
	logic [mctb_pkg::NUM_TIMERS-1:0]  sel_vec;
	logic [mctb_pkg::NUM_TIMERS-1:0]  alloc_vec;
	logic [mctb_pkg::NUM_TIMERS-1:0]  tick_vec;
	logic [mctb_pkg::NUM_TIMERS-1:0]  fire_vec;
	logic [mctb_pkg::NUM_TIMERS:0]    query_chain;
	logic [mctb_pkg::FIRE_W-1:0]      fire_ext;

	logic                             done_q;
	logic [mctb_pkg::MASK_W-1:0]      mask_q;
	logic [mctb_pkg::NEW_ID_W-1:0]    new_id_q;
	logic                             alloc_ok_q;
	logic                             is_expired_q;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// command decode, broadcast to all cells
	always_comb begin
		cmd.tick     = accept & (op == mctb_pkg::OP_TICK);
		cmd.load     = accept & (op == mctb_pkg::OP_START);
		cmd.halt     = accept & (op == mctb_pkg::OP_STOP);
		cmd.value    = mctb_pkg::COUNT_WIDTH'(ticks);
		cmd.periodic = mode;
	end

	assign alloc_avail = (alloc_cnt_q < mctb_pkg::ALLOC_W'(mctb_pkg::NUM_TIMERS));

	// row of channel cells
	assign query_chain[0] = 1'b0;
	for (genvar i = 0; i < mctb_pkg::NUM_TIMERS; i++) begin : g_cell
		localparam logic [mctb_pkg::IDX_W-1:0] CellIdx = mctb_pkg::IDX_W'(i);

		assign sel_vec[i]   = (mctb_pkg::IDX_W'(channel) == CellIdx);
		assign alloc_vec[i] = (mctb_pkg::ALLOC_W'(i) < alloc_cnt_q);
		assign tick_vec[i]  = alloc_vec[i] & (i >= mctb_pkg::FIRST_USER_CHANNEL);

		mctb_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.sel       (sel_vec[i]),
			.alloc     (alloc_vec[i]),
			.tick_en   (tick_vec[i]),
			.query_in  (query_chain[i]),
			.query_out (query_chain[i+1]),
			.fire      (fire_vec[i])
		);
	end

	assign fire_ext = mctb_pkg::FIRE_W'(fire_vec);

	// allocation counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_cnt_q <= mctb_pkg::ALLOC_W'(mctb_pkg::FIRST_USER_CHANNEL);
		end else if (accept && op == mctb_pkg::OP_ALLOC && alloc_avail) begin
			alloc_cnt_q <= alloc_cnt_q + mctb_pkg::ALLOC_W'(1);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// result payload, zero for fields not owned by the op
	always_ff @(posedge clk) begin
		if (accept) begin
			case (op)
				mctb_pkg::OP_TICK: begin
					mask_q       <= fire_ext[mctb_pkg::MASK_W-1:0];
					new_id_q     <= '0;
					alloc_ok_q   <= 1'b0;
					is_expired_q <= 1'b0;
				end
				mctb_pkg::OP_ALLOC: begin
					mask_q       <= '0;
					new_id_q     <= alloc_avail ? mctb_pkg::NEW_ID_W'(alloc_cnt_q) : '0;
					alloc_ok_q   <= alloc_avail;
					is_expired_q <= 1'b0;
				end
				mctb_pkg::OP_QUERY: begin
					mask_q       <= '0;
					new_id_q     <= '0;
					alloc_ok_q   <= 1'b0;
					is_expired_q <= query_chain[mctb_pkg::NUM_TIMERS];
				end
				default: begin
					mask_q       <= '0;
					new_id_q     <= '0;
					alloc_ok_q   <= 1'b0;
					is_expired_q <= 1'b0;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign expired_mask = mask_q;
	assign new_id       = new_id_q;
	assign alloc_ok     = alloc_ok_q;
	assign is_expired   = is_expired_q;

endmodule

// ===== hdl/mctb_checker.sv =====
// Port-level checker for the timer bank, bound to the top level.
// Depends on mctb_pkg and multi_channel_timer_bank_macros.svh.
`include "multi_channel_timer_bank_macros.svh"

module mctb_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [mctb_pkg::OP_W-1:0]        op,
	input  logic [mctb_pkg::CHAN_W-1:0]      channel,
	input  logic [mctb_pkg::TICKS_W-1:0]     ticks,
	input  logic                             mode,
	input  logic                             done,
	input  logic [mctb_pkg::MASK_W-1:0]      expired_mask,
	input  logic [mctb_pkg::NEW_ID_W-1:0]    new_id,
	input  logic                             alloc_ok,
	input  logic                             is_expired
);

	// every accepted transaction gives one result in the next cycle
	`MCTB_ASSERT_NEXT(a_result_follows, clk, arst_n, start && !busy, done)
	// no result without a transaction
	`MCTB_ASSERT_NEXT(a_no_spurious, clk, arst_n, !(start && !busy), !done)
	// a granted allocate never hands out the reserved channel and came from an allocate
	`MCTB_ASSERT_SAME(a_alloc_id, clk, arst_n, done && alloc_ok,
		new_id != mctb_pkg::NEW_ID_W'(mctb_pkg::RESERVED_CHANNEL) &&
		$past(op) == mctb_pkg::OP_ALLOC)
	// allocate and query results carry no expiry bits, and never both at once
	`MCTB_ASSERT_SAME(a_fields_exclusive, clk, arst_n, done && (alloc_ok || is_expired),
		expired_mask == '0 && !(alloc_ok && is_expired))

endmodule

bind multi_channel_timer_bank mctb_checker u_mctb_checker (.*);

// ===== tb/sv/multi_channel_timer_bank_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_channel_timer_bank: directed and random op streams.
// Depends on mctb_pkg and the multi_channel_timer_bank RTL; holds its own shadow of the bank.

import mctb_pkg::*;

// expected outputs of one transaction
typedef struct packed {
	logic [MASK_W-1:0]   mask;
	logic [NEW_ID_W-1:0] id;
	logic                ok;
	logic                expired;
} timer_outcome_t;

// Shadow copy of the timer bank plus the queue of outcomes still to be seen
class timer_bank_shadow;
	logic [COUNT_WIDTH-1:0] period [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] count [NUM_TIMERS];
	bit                     periodic [NUM_TIMERS];
	bit                     running [NUM_TIMERS];
	int                     granted;
	timer_outcome_t         pending [$];
	int                     mismatches;

	function new();
		for (int i = 0; i < NUM_TIMERS; i++) begin
			period[i] = '0;
			count[i] = '0;
			periodic[i] = 1'b0;
			running[i] = 1'b0;
		end
		granted = FIRST_USER_CHANNEL;
		mismatches = 0;
	endfunction

	// advance the shadow by one accepted transaction and queue its outcome
	function void apply_op(logic [OP_W-1:0] opc, logic [CHAN_W-1:0] ch,
		logic [TICKS_W-1:0] tk, logic md);
		timer_outcome_t o;
		o = '0;
		case (opc)
			OP_TICK: begin
				// reserved channel and unallocated channels never count
				for (int i = FIRST_USER_CHANNEL; i < granted && i < NUM_TIMERS; i++) begin
					if (running[i]) begin
						count[i] = count[i] - 1'b1;
						if (count[i] == '0) begin
							if (i < MASK_W)
								o.mask[i] = 1'b1;
							if (periodic[i])
								count[i] = period[i];
							else
								running[i] = 1'b0;
						end
					end
				end
			end
			OP_ALLOC: begin
				if (granted < NUM_TIMERS) begin
					o.id = granted[NEW_ID_W-1:0];
					o.ok = 1'b1;
					granted++;
				end
			end
			OP_START: begin
				if (ch < granted && ch < NUM_TIMERS) begin
					period[ch] = tk[COUNT_WIDTH-1:0];
					count[ch] = tk[COUNT_WIDTH-1:0];
					periodic[ch] = md;
					running[ch] = 1'b1;
				end
			end
			OP_STOP: begin
				if (ch < NUM_TIMERS)
					running[ch] = 1'b0;
			end
			OP_QUERY: begin
				if (ch < NUM_TIMERS)
					o.expired = (count[ch] == '0);
			end
			default: ;
		endcase
		pending.push_back(o);
	endfunction

	// compare one result against the oldest queued outcome
	function void compare_result(logic [MASK_W-1:0] mask, logic [NEW_ID_W-1:0] id,
		logic ok, logic expired);
		timer_outcome_t o;
		if (pending.size() == 0) begin
			$error("result with no transaction outstanding");
			mismatches++;
			return;
		end
		o = pending.pop_front();
		if (mask !== o.mask) begin
			$error("expired_mask: expected %h, got %h", o.mask, mask);
			mismatches++;
		end
		if (id !== o.id) begin
			$error("new_id: expected %h, got %h", o.id, id);
			mismatches++;
		end
		if (ok !== o.ok) begin
			$error("alloc_ok: expected %b, got %b", o.ok, ok);
			mismatches++;
		end
		if (expired !== o.expired) begin
			$error("is_expired: expected %b, got %b", o.expired, expired);
			mismatches++;
		end
	endfunction
endclass

module multi_channel_timer_bank_tb;

	// op codes the block does not decode
	localparam logic [OP_W-1:0] OP_BAD_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_BAD_MID   = 3'd6;
	localparam logic [OP_W-1:0] OP_BAD_LAST  = 3'd7;
	localparam logic [TICKS_W-1:0] TICKS_MAX = '1;
	localparam int RANDOM_OPS   = 400;
	localparam int SETTLE_TICKS = 4;
	localparam int STALL_LIMIT  = 1000;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [OP_W-1:0]     op = '0;
	logic [CHAN_W-1:0]   channel = '0;
	logic [TICKS_W-1:0]  ticks = '0;
	logic                mode = 1'b0;
	logic                done;
	logic [MASK_W-1:0]   expired_mask;
	logic [NEW_ID_W-1:0] new_id;
	logic                alloc_ok;
	logic                is_expired;

	timer_bank_shadow shadow;
	int               quiet_cycles = 0;

	multi_channel_timer_bank uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.channel     (channel),
		.ticks       (ticks),
		.mode        (mode),
		.done        (done),
		.expired_mask(expired_mask),
		.new_id      (new_id),
		.alloc_ok    (alloc_ok),
		.is_expired  (is_expired)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// monitor: note accepted transactions, check results, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				shadow.apply_op(op, channel, ticks, mode);
			if (done)
				shadow.compare_result(expired_mask, new_id, alloc_ok, is_expired);
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("multi_channel_timer_bank_tb: done, errors");
				$finish;
			end
		end
	end

	// offer one transaction and hold it until the block takes it
	task automatic push_op(input logic [OP_W-1:0] o, input logic [CHAN_W-1:0] c,
		input logic [TICKS_W-1:0] t, input logic m);
		start <= 1'b1;
		op <= o;
		channel <= c;
		ticks <= t;
		mode <= m;
		do
			@(posedge clk);
		while (busy);
	endtask

	// idle the command side with junk on the fields
	task automatic pause(input int n);
		if (n > 0) begin
			start <= 1'b0;
			op <= OP_W'($urandom);
			channel <= CHAN_W'($urandom);
			ticks <= $urandom;
			mode <= 1'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	// hold off until every outstanding result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (shadow.pending.size() != 0)
			@(posedge clk);
	endtask

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// small counts so channels expire, plus the extremes and full-width noise
	function automatic logic [TICKS_W-1:0] pick_ticks();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return TICKS_W'($urandom_range(0, 6));
		if (r == 6)
			return '0;
		if (r == 7)
			return TICKS_MAX;
		return $urandom;
	endfunction

	task automatic send_random();
		logic [OP_W-1:0]   o;
		logic [CHAN_W-1:0] c;
		int                r;
		r = $urandom_range(0, 99);
		if (r < 35)
			o = OP_TICK;
		else if (r < 43)
			o = OP_ALLOC;
		else if (r < 68)
			o = OP_START;
		else if (r < 78)
			o = OP_STOP;
		else if (r < 93)
			o = OP_QUERY;
		else
			o = OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
		// mostly allocated channels, sometimes any channel
		if ($urandom_range(0, 3) == 0)
			c = CHAN_W'($urandom_range(0, NUM_TIMERS - 1));
		else
			c = CHAN_W'($urandom_range(0, shadow.granted - 1));
		push_op(o, c, pick_ticks(), 1'($urandom));
	endtask

	// stimulus
	initial begin
		bit no_gaps;
		shadow = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fresh bank: reserved channel reads zero, nothing allocated yet
		push_op(OP_QUERY, 4'd0, '0, 1'b0);
		push_op(OP_TICK, 4'd0, '0, 1'b0);
		push_op(OP_BAD_FIRST, 4'd3, TICKS_MAX, 1'b1);
		push_op(OP_BAD_MID, 4'd15, TICKS_MAX, 1'b1);
		push_op(OP_BAD_LAST, 4'd15, TICKS_MAX, 1'b1);
		push_op(OP_START, 4'd3, 32'd5, 1'b1);
		push_op(OP_START, 4'd15, TICKS_MAX, 1'b0);
		push_op(OP_STOP, 4'd9, '0, 1'b0);
		push_op(OP_QUERY, 4'd15, '0, 1'b0);
		pause(2);
		// reserved channel loads but never counts down
		push_op(OP_START, 4'd0, 32'd1, 1'b0);
		push_op(OP_TICK, 4'd0, '0, 1'b0);
		push_op(OP_QUERY, 4'd0, '0, 1'b0);
		push_op(OP_ALLOC, 4'd0, '0, 1'b0);
		push_op(OP_ALLOC, 4'd0, '0, 1'b0);
		// single-shot and periodic expiry, then stop
		push_op(OP_START, 4'd1, 32'd2, 1'b0);
		push_op(OP_START, 4'd2, 32'd1, 1'b1);
		push_op(OP_TICK, 4'd0, '0, 1'b0);
		pause(1);
		push_op(OP_TICK, 4'd0, '0, 1'b0);
		push_op(OP_QUERY, 4'd1, '0, 1'b0);
		push_op(OP_STOP, 4'd2, '0, 1'b0);
		push_op(OP_TICK, 4'd0, '0, 1'b0);
		// zero period wraps, full-scale count
		push_op(OP_START, 4'd1, '0, 1'b1);
		push_op(OP_START, 4'd2, TICKS_MAX, 1'b1);
		push_op(OP_TICK, 4'd0, '0, 1'b0);
		push_op(OP_QUERY, 4'd1, '0, 1'b0);

		// random part, in segments with and without gaps
		no_gaps = 1'b0;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 40 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			if (n == RANDOM_OPS / 2 || $urandom_range(0, 99) == 0)
				drain();
			// make sure the bank gets filled and a full-bank allocate is seen
			if (n == 3 * RANDOM_OPS / 4) begin
				drain();
				while (shadow.granted < NUM_TIMERS)
					push_op(OP_ALLOC, CHAN_W'($urandom), $urandom, 1'($urandom));
				push_op(OP_ALLOC, CHAN_W'($urandom), $urandom, 1'($urandom));
			end
			send_random();
			if (!no_gaps)
				pause(pick_gap());
		end

		// wind down: wait out every outstanding result, then let the bank settle
		start <= 1'b0;
		@(posedge clk);
		while (shadow.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.pending.size() == 0)
			$display("multi_channel_timer_bank_tb: done, clean");
		else
			$display("multi_channel_timer_bank_tb: done, errors");
		$finish;
	end

endmodule
